### rtl/fsd_pkg.sv
package fsd_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int CODE_W     = 16;
  localparam int SCALE_W    = 34;
  localparam int OFFSET_W   = 30;
  localparam int BITS_W     = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 34;

  // Fixed point: Q.12 values and errors
  localparam int FRAC_W = 12;
  localparam int ERR_W  = FRAC_W + 1;
  localparam int SUM_W  = ERR_W + 4;
  localparam int PROD_W = SAMPLE_W + SCALE_W;
  localparam int VAL_W  = PROD_W - FRAC_W + 2;
  localparam int X_W    = VAL_W + 1;
  localparam int MAXQ_W = CODE_W + FRAC_W;
  localparam int CEIL_W = CODE_W + 1;

  // Reset values of the configuration registers
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'd16777216);
  localparam logic [CODE_W-1:0]  CEIL_RESET  = CODE_W'(255);
  localparam logic [WID_W-1:0]   WIDTH_RESET = WID_W'(1024);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCALE,
    REG_OFFSET,
    REG_OUT_BITS,
    REG_ROW_WIDTH
  } cfg_reg_t;

  typedef logic [COL_W-1:0]        col_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Raster position of one pixel, carried down the pipeline
  typedef struct packed {
    col_t col;
    col_t ur_addr;
    logic col0;
    logic first;
    logic ur_zero;
    logic row_end;
  } pos_t;

  // Line store write request
  typedef struct packed {
    logic we;
    col_t addr;
    err_t data;
  } line_wr_t;

  // Clip a row width to 1..MAX_WIDTH
  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
    eff_width = (w == '0) ? WID_W'(1) :
                (w > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : w;
  endfunction

  // Clamp ceiling in code units: 2^bits - 1 with bits clipped to 1..16
  function automatic logic [CODE_W-1:0] code_ceil(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] n;
    n = (b == '0) ? BITS_W'(1) : (b > BITS_W'(CODE_W)) ? BITS_W'(CODE_W) : b;
    code_ceil = CODE_W'((CEIL_W'(1) << n) - CEIL_W'(1));
  endfunction

endpackage

### rtl/fsd_line_ram.sv
module fsd_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fsd_raster.sv
module fsd_raster import fsd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         advance,
  input  logic                         frame_start,
  output pos_t                         pos,
  output logic [SCALE_W-1:0]           scale,
  output logic signed [OFFSET_W-1:0]   offset,
  output logic [CODE_W-1:0]            ceil
);

  logic [WID_W-1:0] width;
  col_t             column;
  logic             first_row;

  col_t             col_base;
  col_t             col;
  logic [WID_W-1:0] col_inc;
  logic             first;

  // Configuration registers; output bits and row width are stored already clipped
  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= SCALE_RESET;
      offset <= '0;
      ceil   <= CEIL_RESET;
      width  <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCALE:     scale  <= cfg_data[SCALE_W-1:0];
        REG_OFFSET:    offset <= signed'(cfg_data[OFFSET_W-1:0]);
        REG_OUT_BITS:  ceil   <= code_ceil(cfg_data[BITS_W-1:0]);
        REG_ROW_WIDTH: width  <= eff_width(cfg_data[WID_W-1:0]);
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel: frame start and a shrunk width restart the row
  always_comb begin
    col_base = frame_start ? '0 : column;
    col      = ({1'b0, col_base} >= width) ? '0 : col_base;
    first    = frame_start | first_row;
    col_inc  = {1'b0, col} + WID_W'(1);

    pos.col     = col;
    pos.ur_addr = col_inc[COL_W-1:0];
    pos.col0    = (col == '0);
    pos.first   = first;
    pos.row_end = (col_inc == width);
    pos.ur_zero = first | (col_inc >= width);
  end

  // Advance the raster counters on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      first_row <= 1'b1;
    end else if (advance) begin
      if (pos.row_end) begin
        column    <= '0;
        first_row <= 1'b0;
      end else begin
        column    <= col_inc[COL_W-1:0];
        first_row <= first;
      end
    end
  end

endmodule

### rtl/fsd_diffuse.sv
module fsd_diffuse import fsd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  pos_t                      pos,
  input  logic signed [VAL_W-1:0]   value,
  input  err_t                      ur,
  input  logic [CODE_W-1:0]         ceil,
  output logic [CODE_W-1:0]         code,
  output line_wr_t                  line_wr
);

  err_t left_err;
  err_t up_err;
  err_t ul_err;
  err_t err0;

  err_t                     left_v;
  err_t                     up_v;
  err_t                     ul_v;
  err_t                     ur_v;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  e;
  logic signed [X_W-1:0]    x;
  logic signed [X_W-1:0]    maxq_x;
  logic [MAXQ_W-1:0]        xc;
  logic [CODE_W-1:0]        q;
  logic [FRAC_W-1:0]        frac;
  logic                     inc;
  err_t                     res;

  always_comb begin
    // Select neighbour errors, zero outside the image
    left_v = pos.col0 ? '0 : left_err;
    ul_v   = pos.col0 ? '0 : ul_err;
    up_v   = pos.col0 ? (pos.first ? '0 : err0) : up_err;
    ur_v   = pos.ur_zero ? '0 : ur;

    // Weighted sum in Q.16, round to Q.12
    sum = SUM_W'(left_v) * SUM_W'(7) + SUM_W'(ur_v) * SUM_W'(3)
        + SUM_W'(up_v) * SUM_W'(5) + SUM_W'(ul_v);
    e   = (sum + SUM_W'(8)) >>> 4;

    // Add error and clamp to the code range
    x      = X_W'(value) + X_W'(e);
    maxq_x = signed'(X_W'({ceil, {FRAC_W{1'b0}}}));
    if (x[X_W-1]) begin
      xc = '0;
    end else if (x > maxq_x) begin
      xc = {ceil, {FRAC_W{1'b0}}};
    end else begin
      xc = x[MAXQ_W-1:0];
    end

    // Round to nearest, ties to even
    q    = xc[MAXQ_W-1:FRAC_W];
    frac = xc[FRAC_W-1:0];
    inc  = (frac > FRAC_W'(2048)) || ((frac == FRAC_W'(2048)) && q[0]);
    code = q + CODE_W'(inc);

    // Residual: frac, or frac - 4096 when rounded up
    res = signed'({inc, frac});

    line_wr.we   = advance;
    line_wr.addr = pos.col;
    line_wr.data = res;
  end

  // Shift the error window; mirror line entry 0 for the next row start
  always_ff @(posedge clk) begin
    if (rst) begin
      left_err <= '0;
      up_err   <= '0;
      ul_err   <= '0;
      err0     <= '0;
    end else if (advance) begin
      left_err <= res;
      up_err   <= ur_v;
      ul_err   <= up_v;
      if (pos.col0) begin
        err0 <= res;
      end
    end
  end

endmodule

### rtl/floyd_steinberg_dither.sv
// Channel  | Dir | tdata (low bit up) | side band
// s_axis   | in  | sample[15:0]       | tuser: frame_start
// m_axis   | out | code[15:0]         | tlast: row_end
// cfg      | in  | cfg_data: register value, cfg_addr: register index
//
// One pixel per clock unless m_axis stalls; stages and output are all registered.
// The rate is set by the quantize stage, whose left-error feedback is registered.
// Line store: one read (upper-right) at request, one write at quantize; in-flight
// writes are forwarded into each stage. Synchronous reset clears control, errors
// and configuration; the line store is not cleared. Each stage has its own valid,
// so requests are taken while a result waits as long as a stage is free.
module floyd_steinberg_dither import fsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // sample[15:0]
  input  logic                  s_axis_tuser,  // frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CODE_W-1:0]     m_axis_tdata,  // code[15:0]
  output logic                  m_axis_tlast
);

  logic [SCALE_W-1:0]         scale;
  logic signed [OFFSET_W-1:0] offset;
  logic [CODE_W-1:0]          ceil;
  pos_t                       pos0;

  logic v1, v2, v3;
  logic adv1, adv2, adv3, acc, out_free;

  logic [SAMPLE_W-1:0]        sample1;
  pos_t                       pos1;
  logic                       byp1;
  err_t                       bypd1;
  logic [ERR_W-1:0]           rdata;
  err_t                       ur1;

  logic [PROD_W-1:0]          prod2;
  pos_t                       pos2;
  err_t                       ur2;

  logic signed [VAL_W-1:0]    value3;
  pos_t                       pos3;
  err_t                       ur3;

  logic [CODE_W-1:0]          code;
  line_wr_t                   line_wr;
  logic                       hit0, hit1, hit2, hit3;

  fsd_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .advance     (acc),
    .frame_start (s_axis_tuser),
    .pos         (pos0),
    .scale       (scale),
    .offset      (offset),
    .ceil        (ceil)
  );

  fsd_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (ERR_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_wr.we),
    .waddr (line_wr.addr),
    .wdata (line_wr.data),
    .re    (acc),
    .raddr (pos0.ur_addr),
    .rdata (rdata)
  );

  fsd_diffuse u_diffuse (
    .clk     (clk),
    .rst     (rst),
    .advance (adv3),
    .pos     (pos3),
    .value   (value3),
    .ur      (ur3),
    .ceil    (ceil),
    .code    (code),
    .line_wr (line_wr)
  );

  // Stage handshakes
  always_comb begin
    out_free      = !m_axis_tvalid || m_axis_tready;
    adv3          = v3 && out_free;
    adv2          = v2 && (!v3 || adv3);
    adv1          = v1 && (!v2 || adv2);
    s_axis_tready = !v1 || adv1;
    acc           = s_axis_tvalid && s_axis_tready;
  end

  // Forward line writes that land on an upper-right entry still in flight
  always_comb begin
    hit0 = line_wr.we && (line_wr.addr == pos0.ur_addr);
    hit1 = line_wr.we && (line_wr.addr == pos1.ur_addr);
    hit2 = line_wr.we && (line_wr.addr == pos2.ur_addr);
    hit3 = line_wr.we && (line_wr.addr == pos3.ur_addr);
    ur1  = byp1 ? bypd1 : signed'(rdata);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      byp1          <= 1'b0;
    end else begin
      if (acc) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (adv3) begin
        v3 <= 1'b0;
      end
      if (adv3) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (acc) begin
        byp1 <= hit0;
      end else if (hit1) begin
        byp1 <= 1'b1;
      end
    end
  end

  // Stage 1: capture request, line read in flight
  always_ff @(posedge clk) begin
    if (acc) begin
      sample1 <= s_axis_tdata;
      pos1    <= pos0;
      bypd1   <= line_wr.data;
    end else if (hit1) begin
      bypd1   <= line_wr.data;
    end
  end

  // Stage 2: gain multiply
  always_ff @(posedge clk) begin
    if (adv1) begin
      prod2 <= sample1 * scale;
      pos2  <= pos1;
      ur2   <= hit1 ? line_wr.data : ur1;
    end else if (hit2) begin
      ur2   <= line_wr.data;
    end
  end

  // Stage 3: round product to Q.12 and add offset
  always_ff @(posedge clk) begin
    if (adv2) begin
      value3 <= VAL_W'(signed'({1'b0, prod2[PROD_W-1:FRAC_W]}))
              + VAL_W'(offset)
              + VAL_W'({1'b0, prod2[FRAC_W-1]});
      pos3   <= pos2;
      ur3    <= hit2 ? line_wr.data : ur2;
    end else if (hit3) begin
      ur3    <= line_wr.data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv3) begin
      m_axis_tdata <= code;
      m_axis_tlast <= pos3.row_end;
    end
  end

  a_code_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= ceil))
    else $error("output code above clamp ceiling");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v1 && v2 && v3 && m_axis_tvalid && !m_axis_tready))
    else $error("request refused with a free stage");

  a_residual_range: assert property (@(posedge clk) disable iff (rst)
    line_wr.we |-> ((line_wr.data >= -13'sd2048) && (line_wr.data <= 13'sd2048)))
    else $error("residual out of range");

endmodule
